// ===== rtl/dmh_pkg.sv =====
`default_nettype none
package dmh_pkg;
    localparam int unsigned NUM_CPUS = 64;
    localparam int unsigned DL_W = 64;
    localparam int unsigned CPU_W = 6;
    localparam int unsigned CNT_W = 7;
    localparam logic OP_REMOVE = 1'b0;
    localparam logic OP_SET = 1'b1;

    function automatic logic f_earlier(input logic [DL_W-1:0] a, input logic [DL_W-1:0] b);
        logic [DL_W-1:0] d;
        d = a - b;
        return d[DL_W-1];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/deadline_max_heap_by_cpu.sv =====
// an insert sifts up, a key change sifts up or down, and a remove sifts up and then down
// each level sifted up reads one slot and each level sifted down reads up to two
// throughput: one transaction in flight, the next taken the cycle after its result is loaded
// reset clears presence bits, entry count and control state; memories are not cleared
`default_nettype none
module deadline_max_heap_by_cpu
    import dmh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // op, cpu_id[6:1], deadline[70:7], zero fill
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // max_cpu[5:0], not_empty[6], entry_count[13:7], bad_remove[14], zero fill
    output logic [15:0]      m_axis_tdata
);
    localparam int unsigned AW = $clog2(NUM_CPUS);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LOOK    = 4'd1;
    localparam logic [3:0] S_FETCH   = 4'd2;
    localparam logic [3:0] S_START   = 4'd3;
    localparam logic [3:0] S_UP      = 4'd4;
    localparam logic [3:0] S_UP_RD   = 4'd5;
    localparam logic [3:0] S_UP_CMP  = 4'd6;
    localparam logic [3:0] S_DN      = 4'd7;
    localparam logic [3:0] S_DN_RDL  = 4'd8;
    localparam logic [3:0] S_DN_CMPL = 4'd9;
    localparam logic [3:0] S_DN_RDR  = 4'd10;
    localparam logic [3:0] S_DN_CMPR = 4'd11;
    localparam logic [3:0] S_DN_MOVE = 4'd12;
    localparam logic [3:0] S_PLACE   = 4'd13;
    localparam logic [3:0] S_ROOT    = 4'd14;
    localparam logic [3:0] S_OUT     = 4'd15;

    logic [DL_W-1:0]  m_dl [NUM_CPUS];
    logic [CPU_W-1:0] m_cpu [NUM_CPUS];
    logic [AW-1:0]    m_pos [NUM_CPUS];
    logic [NUM_CPUS-1:0] r_present;

    logic [3:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic             r_op;
    logic [CPU_W-1:0] r_cpu;
    logic [DL_W-1:0]  r_dl;
    logic [AW-1:0]    r_i;
    logic [CPU_W-1:0] r_icpu;
    logic [DL_W-1:0]  r_idl;
    logic             r_down_after;
    logic             r_moved;
    logic             r_bad;
    logic [AW-1:0]    r_big;
    logic [DL_W-1:0]  r_bigdl;
    logic [CPU_W-1:0] r_bigcpu;

    logic [AW-1:0]    r_raddr;
    logic [DL_W-1:0]  r_rdl;
    logic [CPU_W-1:0] r_rcpu;
    logic [AW-1:0]    r_rpos;

    logic             w_en;
    logic [AW-1:0]    w_addr;
    logic [DL_W-1:0]  w_dl;
    logic [CPU_W-1:0] w_cpu;
    logic             p_en;
    logic [CPU_W-1:0] p_addr;
    logic [AW-1:0]    p_val;
    logic [CPU_W-1:0] pr_addr;

    logic [15:0]      r_odata;

    logic             in_op;
    logic [CPU_W-1:0] in_cpu;
    logic [DL_W-1:0]  in_dl;
    logic [AW:0]      l_idx;
    logic [AW:0]      r_idx;
    logic [AW-1:0]    n_parent;
    logic [CNT_W-1:0] last;
    logic             out_load;

    assign in_op  = s_axis_tdata[0];
    assign in_cpu = s_axis_tdata[6:1];
    assign in_dl  = s_axis_tdata[70:7];
    assign l_idx = {r_i, 1'b1};
    assign r_idx = l_idx + (AW+1)'(1);
    assign n_parent = (r_i - AW'(1)) >> 1;
    assign last = r_count - CNT_W'(1);
    assign pr_addr = (r_state == S_IDLE) ? in_cpu : r_cpu;
    assign out_load = (r_state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_dl[w_addr]  <= w_dl;
            m_cpu[w_addr] <= w_cpu;
        end
        if (p_en) m_pos[p_addr] <= p_val;
        r_rdl  <= m_dl[r_raddr];
        r_rcpu <= m_cpu[r_raddr];
        r_rpos <= m_pos[pr_addr];
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tdata = r_odata;

    always_comb begin
        w_en = 1'b0; w_addr = r_i; w_dl = r_idl; w_cpu = r_icpu;
        p_en = 1'b0; p_addr = r_icpu; p_val = r_i;
        case (r_state)
            S_UP_CMP: begin
                // parent drops into the hole
                if (f_earlier(r_rdl, r_idl)) begin
                    w_en = 1'b1; w_dl = r_rdl; w_cpu = r_rcpu;
                    p_en = 1'b1; p_addr = r_rcpu;
                end
            end
            S_DN_MOVE: begin
                // later child rises into the hole
                if (r_moved) begin
                    w_en = 1'b1; w_dl = r_bigdl; w_cpu = r_bigcpu;
                    p_en = 1'b1; p_addr = r_bigcpu;
                end
            end
            S_PLACE: begin
                w_en = 1'b1;
                p_en = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_present <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (out_load) m_axis_tvalid <= 1'b1;
            else if (m_axis_tready) m_axis_tvalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op <= in_op; r_cpu <= in_cpu; r_dl <= in_dl;
                        r_bad <= 1'b0;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_icpu <= r_cpu;
                    r_idl <= r_dl;
                    if (r_op == OP_SET) begin
                        if (r_present[r_cpu]) begin
                            r_i <= r_rpos; r_raddr <= r_rpos;
                            r_state <= S_FETCH;
                        end else if (r_count < CNT_W'(NUM_CPUS)) begin
                            r_i <= r_count[AW-1:0];
                            r_count <= r_count + CNT_W'(1);
                            r_present[r_cpu] <= 1'b1;
                            r_down_after <= 1'b0;
                            r_state <= S_UP;
                        end else begin
                            r_raddr <= '0; r_state <= S_ROOT;
                        end
                    end else begin
                        if (!r_present[r_cpu] || r_count == '0) begin
                            r_bad <= 1'b1; r_raddr <= '0; r_state <= S_ROOT;
                        end else begin
                            r_present[r_cpu] <= 1'b0;
                            r_count <= last;
                            if ({1'b0, r_rpos} < last) begin
                                // last entry fills the freed slot
                                r_i <= r_rpos;
                                r_raddr <= last[AW-1:0];
                                r_down_after <= 1'b1;
                                r_state <= S_FETCH;
                            end else begin
                                r_raddr <= '0; r_state <= S_ROOT;
                            end
                        end
                    end
                end
                S_FETCH: r_state <= S_START;
                S_START: begin
                    if (r_op == OP_SET) begin
                        r_down_after <= 1'b0;
                        r_state <= f_earlier(r_dl, r_rdl) ? S_DN : S_UP;
                    end else begin
                        r_idl <= r_rdl; r_icpu <= r_rcpu;
                        r_state <= S_UP;
                    end
                end
                S_UP: begin
                    if (r_i == '0) begin
                        r_state <= r_down_after ? S_DN : S_PLACE;
                    end else begin
                        r_raddr <= n_parent; r_state <= S_UP_RD;
                    end
                end
                S_UP_RD: r_state <= S_UP_CMP;
                S_UP_CMP: begin
                    if (f_earlier(r_rdl, r_idl)) begin
                        r_i <= r_raddr; r_state <= S_UP;
                    end else begin
                        r_state <= r_down_after ? S_DN : S_PLACE;
                    end
                end
                S_DN: begin
                    if (l_idx < r_count) begin
                        r_raddr <= l_idx[AW-1:0]; r_state <= S_DN_RDL;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_DN_RDL: r_state <= S_DN_CMPL;
                S_DN_CMPL: begin
                    if (f_earlier(r_idl, r_rdl)) begin
                        r_moved <= 1'b1; r_big <= r_raddr;
                        r_bigdl <= r_rdl; r_bigcpu <= r_rcpu;
                    end else begin
                        r_moved <= 1'b0; r_bigdl <= r_idl;
                    end
                    if (r_idx < r_count) begin
                        r_raddr <= r_idx[AW-1:0]; r_state <= S_DN_RDR;
                    end else begin
                        r_state <= S_DN_MOVE;
                    end
                end
                S_DN_RDR: r_state <= S_DN_CMPR;
                S_DN_CMPR: begin
                    if (f_earlier(r_bigdl, r_rdl)) begin
                        r_moved <= 1'b1; r_big <= r_raddr;
                        r_bigdl <= r_rdl; r_bigcpu <= r_rcpu;
                    end
                    r_state <= S_DN_MOVE;
                end
                S_DN_MOVE: begin
                    if (r_moved) begin
                        r_i <= r_big; r_state <= S_DN;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_raddr <= '0; r_state <= S_ROOT;
                end
                S_ROOT: r_state <= S_OUT;
                S_OUT: begin
                    if (out_load) begin
                        r_odata <= {1'b0, r_bad, r_count,
                                    (r_count != '0), (r_count != '0) ? r_rcpu : CPU_W'(0)};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
